// ===== hdl/rcv_pkg.sv =====
package rcv_pkg;

    // Input and result word widths.
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned TDATA_W = 72;

    // Result queue geometry.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = 2;
    localparam int unsigned FIFO_CW    = 3;

    // Container limits and markers.
    localparam logic [31:0] TOTAL_MIN  = 32'd8;
    localparam logic [7:0]  COUNT_MAX  = 8'hFF;
    localparam logic [15:0] AUDIO_MARK = 16'h000c;

    // Resource type codes.
    localparam logic [3:0] RES_VIDEO = 4'd1;
    localparam logic [3:0] RES_AUDIO = 4'd2;
    localparam logic [3:0] RES_IMAGE = 4'd4;
    localparam logic [3:0] RES_TEXT  = 4'd5;

    // Result kinds.
    localparam logic KIND_DESC    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict scores.
    localparam logic [1:0] SCORE_REJECT  = 2'd0;
    localparam logic [1:0] SCORE_QUARTER = 2'd1;
    localparam logic [1:0] SCORE_HALF    = 2'd2;
    localparam logic [1:0] SCORE_THREEQ  = 2'd3;

    typedef enum logic [2:0] {
        PH_TOTAL,
        PH_COUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  rtype;
        logic [31:0] offset;
        logic [29:0] nbytes;
        logic [1:0]  score;
        logic        last;
    } result_t;

    // Results produced by one processed word, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== hdl/rcv_core.sv =====
module rcv_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [rcv_pkg::WORD_W-1:0] word,
    input  logic                      eos,
    output rcv_pkg::push_t            push
);

    rcv_pkg::phase_t phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] total_reg, total_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [27:0] left_reg, left_next;
    logic [1:0]  idx_reg, idx_next;
    logic        audio_pay_reg, audio_pay_next;
    logic        aud_verified_reg, aud_verified_next;

    logic [3:0]  hdr_type;
    logic [27:0] hdr_size;
    logic        type_ok;
    logic [31:0] end_h;
    logic [31:0] end_p;
    logic [31:0] end_sel;
    logic [31:0] total_plus4;
    logic [1:0]  full_score;
    logic        last_hdr;
    logic [7:0]  hdr_inc;
    logic [27:0] left_dec;
    logic        desc_v;
    logic        verd_v;
    logic        clear;
    logic [1:0]  verd_score;

    // Header fields and end-offset arithmetic.
    assign hdr_type    = word[31:28];
    assign hdr_size    = word[27:0];
    assign type_ok     = (hdr_type == rcv_pkg::RES_VIDEO) || (hdr_type == rcv_pkg::RES_AUDIO) ||
                         (hdr_type == rcv_pkg::RES_IMAGE) || (hdr_type == rcv_pkg::RES_TEXT);
    assign end_h       = pos_reg + 32'd4 + {2'b00, hdr_size, 2'b00};
    assign end_p       = pos_reg + {2'b00, left_reg, 2'b00};
    assign end_sel     = (phase_reg == rcv_pkg::PH_HEADER) ? end_h : end_p;
    assign total_plus4 = total_reg + 32'd4;
    assign full_score  = (end_sel == total_plus4) ? rcv_pkg::SCORE_THREEQ : rcv_pkg::SCORE_HALF;
    assign last_hdr    = (hdr_reg == count_reg);
    assign hdr_inc     = hdr_reg + 8'd1;
    assign left_dec    = left_reg - 28'd1;

    // Parser next state and result selection for one word.
    always_comb
    begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        total_next        = total_reg;
        count_next        = count_reg;
        hdr_next          = hdr_reg;
        left_next         = left_reg;
        idx_next          = idx_reg;
        audio_pay_next    = audio_pay_reg;
        aud_verified_next = aud_verified_reg;
        desc_v            = 1'b0;
        verd_v            = 1'b0;
        verd_score        = rcv_pkg::SCORE_REJECT;
        clear             = 1'b0;

        if (fire)
        begin
            if (phase_reg == rcv_pkg::PH_DONE)
            begin
                clear = eos;
            end
            else if (eos && ((phase_reg == rcv_pkg::PH_TOTAL) ||
                             (phase_reg == rcv_pkg::PH_COUNT) ||
                             ((phase_reg == rcv_pkg::PH_HEADER) && (hdr_reg == 8'd0))))
            begin
                // The stream ended before any resource was seen.
                verd_v = 1'b1;
                clear  = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 32'd4;
                unique case (phase_reg)
                    rcv_pkg::PH_TOTAL:
                    begin
                        total_next = word;
                        if (word < rcv_pkg::TOTAL_MIN)
                        begin
                            verd_v = 1'b1;
                        end
                        else
                        begin
                            phase_next = rcv_pkg::PH_COUNT;
                        end
                    end
                    rcv_pkg::PH_COUNT:
                    begin
                        if ((word == 32'd0) || (word > {24'd0, rcv_pkg::COUNT_MAX}))
                        begin
                            verd_v = 1'b1;
                        end
                        else
                        begin
                            count_next = word[7:0];
                            phase_next = rcv_pkg::PH_HEADER;
                        end
                    end
                    rcv_pkg::PH_HEADER:
                    begin
                        if (!type_ok || (hdr_size == 28'd0) ||
                            ((hdr_type == rcv_pkg::RES_AUDIO) && (hdr_size < 28'd4)))
                        begin
                            verd_v = 1'b1;
                        end
                        else
                        begin
                            hdr_next = hdr_inc;
                            desc_v   = 1'b1;
                            if ((hdr_inc == count_reg) && (hdr_type != rcv_pkg::RES_AUDIO))
                            begin
                                verd_v     = 1'b1;
                                verd_score = full_score;
                            end
                            else
                            begin
                                phase_next     = rcv_pkg::PH_PAYLOAD;
                                left_next      = hdr_size;
                                idx_next       = 2'd0;
                                audio_pay_next = (hdr_type == rcv_pkg::RES_AUDIO);
                            end
                        end
                    end
                    rcv_pkg::PH_PAYLOAD:
                    begin
                        // Audio marker checks on the third and fourth payload words.
                        if (audio_pay_reg)
                        begin
                            if ((idx_reg == 2'd2) && (word != 32'd0))
                            begin
                                verd_v = 1'b1;
                            end
                            else if (idx_reg == 2'd3)
                            begin
                                if (word[15:0] != rcv_pkg::AUDIO_MARK)
                                begin
                                    verd_v = 1'b1;
                                end
                                else
                                begin
                                    aud_verified_next = 1'b1;
                                    audio_pay_next    = 1'b0;
                                    if (last_hdr)
                                    begin
                                        verd_v     = 1'b1;
                                        verd_score = full_score;
                                    end
                                end
                            end
                        end
                        // Skip one payload word.
                        if (!verd_v)
                        begin
                            if (idx_reg != 2'd3)
                            begin
                                idx_next = idx_reg + 2'd1;
                            end
                            left_next = left_dec;
                            if (left_dec == 28'd0)
                            begin
                                audio_pay_next = 1'b0;
                                if (last_hdr)
                                begin
                                    verd_v     = 1'b1;
                                    verd_score = full_score;
                                end
                                else
                                begin
                                    phase_next = rcv_pkg::PH_HEADER;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (verd_v)
                begin
                    phase_next = rcv_pkg::PH_DONE;
                end

                // End of stream: clear the parser and give a verdict if none is given yet.
                if (eos)
                begin
                    clear = 1'b1;
                    if (!verd_v)
                    begin
                        verd_v = 1'b1;
                        if ((phase_next == rcv_pkg::PH_PAYLOAD) && (hdr_next == count_reg))
                        begin
                            verd_score = full_score;
                        end
                        else if (aud_verified_next || (hdr_next >= 8'd3))
                        begin
                            verd_score = rcv_pkg::SCORE_HALF;
                        end
                        else if (hdr_next >= 8'd1)
                        begin
                            verd_score = rcv_pkg::SCORE_QUARTER;
                        end
                        else
                        begin
                            verd_score = rcv_pkg::SCORE_REJECT;
                        end
                    end
                end
            end
        end

        if (clear)
        begin
            phase_next        = rcv_pkg::PH_TOTAL;
            pos_next          = 32'd0;
            total_next        = 32'd0;
            count_next        = 8'd0;
            hdr_next          = 8'd0;
            left_next         = 28'd0;
            idx_next          = 2'd0;
            audio_pay_next    = 1'b0;
            aud_verified_next = 1'b0;
        end
    end

    // Result words for the queue: descriptor first, verdict last.
    always_comb
    begin
        rcv_pkg::result_t desc;
        rcv_pkg::result_t verd;
        desc.kind   = rcv_pkg::KIND_DESC;
        desc.rtype  = hdr_type;
        desc.offset = pos_reg;
        desc.nbytes = {hdr_size, 2'b00};
        desc.score  = rcv_pkg::SCORE_REJECT;
        desc.last   = !verd_v;
        verd.kind   = rcv_pkg::KIND_VERDICT;
        verd.rtype  = 4'd0;
        verd.offset = 32'd0;
        verd.nbytes = 30'd0;
        verd.score  = verd_score;
        verd.last   = 1'b1;
        push.count  = {1'b0, desc_v} + {1'b0, verd_v};
        push.first  = desc_v ? desc : verd;
        push.second = verd;
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= rcv_pkg::PH_TOTAL;
            pos_reg          <= 32'd0;
            total_reg        <= 32'd0;
            count_reg        <= 8'd0;
            hdr_reg          <= 8'd0;
            left_reg         <= 28'd0;
            idx_reg          <= 2'd0;
            audio_pay_reg    <= 1'b0;
            aud_verified_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            total_reg        <= total_next;
            count_reg        <= count_next;
            hdr_reg          <= hdr_next;
            left_reg         <= left_next;
            idx_reg          <= idx_next;
            audio_pay_reg    <= audio_pay_next;
            aud_verified_reg <= aud_verified_next;
        end
    end

    // A word with two results is always a descriptor followed by a verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |->
            ((push.first.kind == rcv_pkg::KIND_DESC) &&
             (push.second.kind == rcv_pkg::KIND_VERDICT)))
        else $error("rcv_core: two results without descriptor then verdict");

    // The end of a stream always leaves the parser waiting for a new total.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && eos) |=> (phase_reg == rcv_pkg::PH_TOTAL) && (pos_reg == 32'd0))
        else $error("rcv_core: state not cleared after end of stream");

endmodule

// ===== hdl/rcv_fifo.sv =====
module rcv_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rcv_pkg::push_t              push,
    output logic                        room,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [rcv_pkg::TDATA_W-1:0] m_tdata,  // type[3:0], offset[35:4], bytes[65:36], score[67:66]
    output logic                        m_tuser,  // result kind
    output logic                        m_tlast   // last result of its input word
);

    rcv_pkg::result_t mem [rcv_pkg::FIFO_DEPTH];
    logic [rcv_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [rcv_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [rcv_pkg::FIFO_CW-1:0] cnt_reg;
    logic                        pop;
    rcv_pkg::result_t            head;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    // Room for the two results a single word can cause.
    assign room     = (cnt_reg <= rcv_pkg::FIFO_CW'(rcv_pkg::FIFO_DEPTH - 2));

    // Output word from the head entry.
    assign head    = mem[rd_ptr_reg];
    assign m_tdata = {4'd0, head.score, head.nbytes, head.offset, head.rtype};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    // Result storage, up to two writes per cycle.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + rcv_pkg::FIFO_AW'(1)] <= push.second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + rcv_pkg::FIFO_AW'(push.count);
            rd_ptr_reg <= rd_ptr_reg + rcv_pkg::FIFO_AW'(pop);
            cnt_reg    <= cnt_reg + rcv_pkg::FIFO_CW'(push.count) - rcv_pkg::FIFO_CW'(pop);
        end
    end

    // The fill level never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rcv_pkg::FIFO_CW'(rcv_pkg::FIFO_DEPTH))
        else $error("rcv_fifo: fill level beyond depth");

    // Results are only pushed where they fit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |->
            ((cnt_reg + rcv_pkg::FIFO_CW'(push.count)) <= rcv_pkg::FIFO_CW'(rcv_pkg::FIFO_DEPTH)))
        else $error("rcv_fifo: push overflows the queue");

endmodule

// ===== hdl/resource_chain_validator.sv =====
// Resource chain validator.
// Slave channel: one little-endian 32-bit stream word per transfer in s_tdata,
// with s_tlast marking the final word of a stream. Master channel: result words,
// either a resource descriptor (m_tuser low: type, header byte offset, payload
// bytes) or the stream's final verdict (m_tuser high: score 0 to 3). m_tlast is
// set on the last result that an input word causes.
// Each accepted word is held in an input register and parsed once the queue has
// room; its zero, one or two results are then written to a four-entry result
// queue and offered from there.
// Throughput is one word per cycle while the queue drains; a held word is parsed
// only when the queue can hold two more results, so a stalled receiver holds off
// the sender after a few words and no result is ever lost.
// After the verdict, further words of the same stream are consumed silently.
// Reset, and the end of every stream, return the parser to waiting for the
// declared-total word at byte offset zero. Reset also empties the queue.
module resource_chain_validator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // stream_word
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // resource_type, resource_offset, resource_bytes, verdict_score
    output logic        m_tuser,   // result_kind
    output logic        m_tlast    // final_result
);

    logic                              in_valid_reg;
    logic [rcv_pkg::WORD_W-1:0]        word_reg;
    logic                              eos_reg;
    logic                              room;
    logic                              fire;
    rcv_pkg::push_t                    push;

    // A held word is parsed once the queue has room for its results.
    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg <= s_tdata;
            eos_reg  <= s_tlast;
        end
    end

    rcv_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .word  (word_reg),
        .eos   (eos_reg),
        .push  (push)
    );

    rcv_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
